@@ hdl/qco_pkg.sv @@
// ----------------------------------------------------------------------------
// qco_pkg
// Shared constants and types for the quadrilateral corner ordering pipeline.
// ----------------------------------------------------------------------------
package qco_pkg;

  // default coordinate width, pixels
  localparam int unsigned COORD_BITS_DEF = 12;

  // four corners per transaction, addressed by a two-bit input index
  localparam int unsigned NUM_PTS  = 4;
  localparam int unsigned IDX_BITS = $clog2(NUM_PTS);

  typedef logic [IDX_BITS-1:0] idx_t;

endpackage

@@ hdl/quad_corner_order_unit.sv @@
// ----------------------------------------------------------------------------
// quad_corner_order_unit
// Orders four quadrilateral corners as top-left, top-right, bottom-right,
// bottom-left.
// ----------------------------------------------------------------------------
// The unit takes one transaction of four points per cycle when the output
// side is not stalled. The four register stages are: sort network layers
// one and two; last sort layer plus the top-left / bottom-left pick by y;
// offset squaring of the two right points; distance sum, top-right pick and
// output register. Every stage holds its data under backpressure and takes a
// new transaction as soon as it empties, so throughput is one transaction per
// cycle. Ties in x, y or distance go to the point with the lower input index;
// the unit holds no state between transactions.
module quad_corner_order_unit #(
  parameter int unsigned COORD_BITS = qco_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] in_x0_i,
  input  logic [COORD_BITS-1:0] in_y0_i,
  input  logic [COORD_BITS-1:0] in_x1_i,
  input  logic [COORD_BITS-1:0] in_y1_i,
  input  logic [COORD_BITS-1:0] in_x2_i,
  input  logic [COORD_BITS-1:0] in_y2_i,
  input  logic [COORD_BITS-1:0] in_x3_i,
  input  logic [COORD_BITS-1:0] in_y3_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] top_left_x_o,
  output logic [COORD_BITS-1:0] top_left_y_o,
  output logic [COORD_BITS-1:0] top_right_x_o,
  output logic [COORD_BITS-1:0] top_right_y_o,
  output logic [COORD_BITS-1:0] bottom_right_x_o,
  output logic [COORD_BITS-1:0] bottom_right_y_o,
  output logic [COORD_BITS-1:0] bottom_left_x_o,
  output logic [COORD_BITS-1:0] bottom_left_y_o
);
  import qco_pkg::*;

  logic [NUM_PTS-1:0][COORD_BITS-1:0] in_x, in_y;

  // sort to distance
  logic                         s_valid, s_ready;
  logic [COORD_BITS-1:0]        s_tl_x, s_tl_y, s_bl_x, s_bl_y;
  logic [1:0][COORD_BITS-1:0]   s_rx, s_ry;
  idx_t [1:0]                   s_ridx;

  // distance to select
  logic                         d_valid, d_ready;
  logic [COORD_BITS-1:0]        d_tl_x, d_tl_y, d_bl_x, d_bl_y;
  logic [1:0][COORD_BITS-1:0]   d_rx, d_ry;
  idx_t [1:0]                   d_ridx;
  logic [1:0][2*COORD_BITS-1:0] d_sqx, d_sqy;

  assign in_x = {in_x3_i, in_x2_i, in_x1_i, in_x0_i};
  assign in_y = {in_y3_i, in_y2_i, in_y1_i, in_y0_i};

  qco_sort #(
    .COORD_BITS(COORD_BITS)
  ) u_sort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .x_i     (in_x),
    .y_i     (in_y),
    .valid_o (s_valid),
    .ready_i (s_ready),
    .tl_x_o  (s_tl_x),
    .tl_y_o  (s_tl_y),
    .bl_x_o  (s_bl_x),
    .bl_y_o  (s_bl_y),
    .rx_o    (s_rx),
    .ry_o    (s_ry),
    .ridx_o  (s_ridx)
  );

  qco_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .ready_o (s_ready),
    .tl_x_i  (s_tl_x),
    .tl_y_i  (s_tl_y),
    .bl_x_i  (s_bl_x),
    .bl_y_i  (s_bl_y),
    .rx_i    (s_rx),
    .ry_i    (s_ry),
    .ridx_i  (s_ridx),
    .valid_o (d_valid),
    .ready_i (d_ready),
    .tl_x_o  (d_tl_x),
    .tl_y_o  (d_tl_y),
    .bl_x_o  (d_bl_x),
    .bl_y_o  (d_bl_y),
    .rx_o    (d_rx),
    .ry_o    (d_ry),
    .ridx_o  (d_ridx),
    .sqx_o   (d_sqx),
    .sqy_o   (d_sqy)
  );

  qco_select #(
    .COORD_BITS(COORD_BITS)
  ) u_select (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (d_valid),
    .ready_o          (d_ready),
    .tl_x_i           (d_tl_x),
    .tl_y_i           (d_tl_y),
    .bl_x_i           (d_bl_x),
    .bl_y_i           (d_bl_y),
    .rx_i             (d_rx),
    .ry_i             (d_ry),
    .ridx_i           (d_ridx),
    .sqx_i            (d_sqx),
    .sqy_i            (d_sqy),
    .valid_o          (out_valid_o),
    .ready_i          (out_ready_i),
    .top_left_x_o     (top_left_x_o),
    .top_left_y_o     (top_left_y_o),
    .top_right_x_o    (top_right_x_o),
    .top_right_y_o    (top_right_y_o),
    .bottom_right_x_o (bottom_right_x_o),
    .bottom_right_y_o (bottom_right_y_o),
    .bottom_left_x_o  (bottom_left_x_o),
    .bottom_left_y_o  (bottom_left_y_o)
  );

endmodule

@@ hdl/qco_sort.sv @@
// ----------------------------------------------------------------------------
// qco_sort
// Two pipeline stages: the first two layers of a four-input sort network on
// (x, index), then the last layer, pair split and top-left / bottom-left pick.
// ----------------------------------------------------------------------------
module qco_sort #(
  parameter int unsigned COORD_BITS = qco_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  logic [qco_pkg::NUM_PTS-1:0][COORD_BITS-1:0]   x_i,
  input  logic [qco_pkg::NUM_PTS-1:0][COORD_BITS-1:0]   y_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output logic [COORD_BITS-1:0]                         tl_x_o,
  output logic [COORD_BITS-1:0]                         tl_y_o,
  output logic [COORD_BITS-1:0]                         bl_x_o,
  output logic [COORD_BITS-1:0]                         bl_y_o,
  output logic [1:0][COORD_BITS-1:0]                    rx_o,
  output logic [1:0][COORD_BITS-1:0]                    ry_o,
  output qco_pkg::idx_t [1:0]                           ridx_o
);
  import qco_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    idx_t                  idx;
  } pt_t;

  // a ranks strictly further left than b
  function automatic logic left_of(input pt_t a, input pt_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.idx < b.idx));
  endfunction

  pt_t              pin   [NUM_PTS];
  pt_t              l1    [NUM_PTS];
  pt_t              l2    [NUM_PTS];
  pt_t              s1_q  [NUM_PTS];
  logic             s1_valid_q;
  logic             s1_ready;
  logic             s1_load;

  pt_t              lmid, rmid, tl_d, bl_d;
  logic             s2_load;
  logic             s2_valid_q;
  pt_t              tl_q, bl_q, r0_q, r1_q;

  // tag points with their input index
  always_comb begin
    for (int k = 0; k < NUM_PTS; k++) begin
      pin[k].x   = x_i[k];
      pin[k].y   = y_i[k];
      pin[k].idx = idx_t'(k);
    end
  end

  // sort layers one and two: pairs (0,1),(2,3) then (0,2),(1,3)
  always_comb begin
    l1[0] = left_of(pin[1], pin[0]) ? pin[1] : pin[0];
    l1[1] = left_of(pin[1], pin[0]) ? pin[0] : pin[1];
    l1[2] = left_of(pin[3], pin[2]) ? pin[3] : pin[2];
    l1[3] = left_of(pin[3], pin[2]) ? pin[2] : pin[3];
    l2[0] = left_of(l1[2], l1[0]) ? l1[2] : l1[0];
    l2[2] = left_of(l1[2], l1[0]) ? l1[0] : l1[2];
    l2[1] = left_of(l1[3], l1[1]) ? l1[3] : l1[1];
    l2[3] = left_of(l1[3], l1[1]) ? l1[1] : l1[3];
  end

  // stage 1 handshake
  assign s1_ready = !s1_valid_q || s2_load || !s2_valid_q || ready_i;
  assign ready_o  = s1_ready;
  assign s1_load  = valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= l2;
    end
  end

  // last sort layer on the middle pair, then top-left by (y, index)
  always_comb begin
    lmid = left_of(s1_q[2], s1_q[1]) ? s1_q[2] : s1_q[1];
    rmid = left_of(s1_q[2], s1_q[1]) ? s1_q[1] : s1_q[2];
    if ((lmid.y < s1_q[0].y) || ((lmid.y == s1_q[0].y) && (lmid.idx < s1_q[0].idx))) begin
      tl_d = lmid;
      bl_d = s1_q[0];
    end else begin
      tl_d = s1_q[0];
      bl_d = lmid;
    end
  end

  // stage 2 handshake
  assign s2_load = s1_valid_q && (!s2_valid_q || ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s2_valid_q || ready_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      tl_q <= tl_d;
      bl_q <= bl_d;
      r0_q <= rmid;
      r1_q <= s1_q[3];
    end
  end

  assign valid_o   = s2_valid_q;
  assign tl_x_o    = tl_q.x;
  assign tl_y_o    = tl_q.y;
  assign bl_x_o    = bl_q.x;
  assign bl_y_o    = bl_q.y;
  assign rx_o[0]   = r0_q.x;
  assign ry_o[0]   = r0_q.y;
  assign ridx_o[0] = r0_q.idx;
  assign rx_o[1]   = r1_q.x;
  assign ry_o[1]   = r1_q.y;
  assign ridx_o[1] = r1_q.idx;

endmodule

@@ hdl/qco_dist.sv @@
// ----------------------------------------------------------------------------
// qco_dist
// One pipeline stage: absolute offsets of both right points from top-left
// and their squares.
// ----------------------------------------------------------------------------
module qco_dist #(
  parameter int unsigned COORD_BITS = qco_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [COORD_BITS-1:0]             tl_x_i,
  input  logic [COORD_BITS-1:0]             tl_y_i,
  input  logic [COORD_BITS-1:0]             bl_x_i,
  input  logic [COORD_BITS-1:0]             bl_y_i,
  input  logic [1:0][COORD_BITS-1:0]        rx_i,
  input  logic [1:0][COORD_BITS-1:0]        ry_i,
  input  qco_pkg::idx_t [1:0]               ridx_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [COORD_BITS-1:0]             tl_x_o,
  output logic [COORD_BITS-1:0]             tl_y_o,
  output logic [COORD_BITS-1:0]             bl_x_o,
  output logic [COORD_BITS-1:0]             bl_y_o,
  output logic [1:0][COORD_BITS-1:0]        rx_o,
  output logic [1:0][COORD_BITS-1:0]        ry_o,
  output qco_pkg::idx_t [1:0]               ridx_o,
  output logic [1:0][2*COORD_BITS-1:0]      sqx_o,
  output logic [1:0][2*COORD_BITS-1:0]      sqy_o
);
  import qco_pkg::*;

  logic                         valid_q;
  logic                         load;
  logic [1:0][COORD_BITS-1:0]   dx, dy;
  logic [1:0][2*COORD_BITS-1:0] sqx_d, sqy_d;
  logic [1:0][2*COORD_BITS-1:0] sqx_q, sqy_q;
  logic [COORD_BITS-1:0]        tl_x_q, tl_y_q, bl_x_q, bl_y_q;
  logic [1:0][COORD_BITS-1:0]   rx_q, ry_q;
  idx_t [1:0]                   ridx_q;

  // offsets and squares
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      dx[k]    = (rx_i[k] > tl_x_i) ? (rx_i[k] - tl_x_i) : (tl_x_i - rx_i[k]);
      dy[k]    = (ry_i[k] > tl_y_i) ? (ry_i[k] - tl_y_i) : (tl_y_i - ry_i[k]);
      sqx_d[k] = {{COORD_BITS{1'b0}}, dx[k]} * {{COORD_BITS{1'b0}}, dx[k]};
      sqy_d[k] = {{COORD_BITS{1'b0}}, dy[k]} * {{COORD_BITS{1'b0}}, dy[k]};
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      tl_x_q <= tl_x_i;
      tl_y_q <= tl_y_i;
      bl_x_q <= bl_x_i;
      bl_y_q <= bl_y_i;
      rx_q   <= rx_i;
      ry_q   <= ry_i;
      ridx_q <= ridx_i;
    end
  end

  assign valid_o = valid_q;
  assign tl_x_o  = tl_x_q;
  assign tl_y_o  = tl_y_q;
  assign bl_x_o  = bl_x_q;
  assign bl_y_o  = bl_y_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign ridx_o  = ridx_q;
  assign sqx_o   = sqx_q;
  assign sqy_o   = sqy_q;

endmodule

@@ hdl/qco_select.sv @@
// ----------------------------------------------------------------------------
// qco_select
// Output stage: sums the squared offsets, picks top-right as the nearer
// right point (lower index on a tie) and holds the ordered corners.
// ----------------------------------------------------------------------------
module qco_select #(
  parameter int unsigned COORD_BITS = qco_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [COORD_BITS-1:0]             tl_x_i,
  input  logic [COORD_BITS-1:0]             tl_y_i,
  input  logic [COORD_BITS-1:0]             bl_x_i,
  input  logic [COORD_BITS-1:0]             bl_y_i,
  input  logic [1:0][COORD_BITS-1:0]        rx_i,
  input  logic [1:0][COORD_BITS-1:0]        ry_i,
  input  qco_pkg::idx_t [1:0]               ridx_i,
  input  logic [1:0][2*COORD_BITS-1:0]      sqx_i,
  input  logic [1:0][2*COORD_BITS-1:0]      sqy_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [COORD_BITS-1:0]             top_left_x_o,
  output logic [COORD_BITS-1:0]             top_left_y_o,
  output logic [COORD_BITS-1:0]             top_right_x_o,
  output logic [COORD_BITS-1:0]             top_right_y_o,
  output logic [COORD_BITS-1:0]             bottom_right_x_o,
  output logic [COORD_BITS-1:0]             bottom_right_y_o,
  output logic [COORD_BITS-1:0]             bottom_left_x_o,
  output logic [COORD_BITS-1:0]             bottom_left_y_o
);
  import qco_pkg::*;

  logic                         valid_q;
  logic                         load;
  logic [1:0][2*COORD_BITS:0]   dsum;
  logic                         pick1;
  logic [COORD_BITS-1:0]        tl_x_q, tl_y_q, tr_x_q, tr_y_q;
  logic [COORD_BITS-1:0]        br_x_q, br_y_q, bl_x_q, bl_y_q;

  // squared distance to top-left, exact
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      dsum[k] = {1'b0, sqx_i[k]} + {1'b0, sqy_i[k]};
    end
  end

  assign pick1 = (dsum[1] < dsum[0]) || ((dsum[1] == dsum[0]) && (ridx_i[1] < ridx_i[0]));

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      tl_x_q <= tl_x_i;
      tl_y_q <= tl_y_i;
      bl_x_q <= bl_x_i;
      bl_y_q <= bl_y_i;
      tr_x_q <= pick1 ? rx_i[1] : rx_i[0];
      tr_y_q <= pick1 ? ry_i[1] : ry_i[0];
      br_x_q <= pick1 ? rx_i[0] : rx_i[1];
      br_y_q <= pick1 ? ry_i[0] : ry_i[1];
    end
  end

  assign valid_o          = valid_q;
  assign top_left_x_o     = tl_x_q;
  assign top_left_y_o     = tl_y_q;
  assign top_right_x_o    = tr_x_q;
  assign top_right_y_o    = tr_y_q;
  assign bottom_right_x_o = br_x_q;
  assign bottom_right_y_o = br_y_q;
  assign bottom_left_x_o  = bl_x_q;
  assign bottom_left_y_o  = bl_y_q;

endmodule

@@ tb/sv/quad_corner_order_unit_tb.sv @@
// ----------------------------------------------------------------------------
// quad_corner_order_unit_tb
// Self-checking bench for the quadrilateral corner ordering unit. A queue of
// quads (directed corner cases, then random shapes) feeds a handshake driver.
// Each accepted quad is ordered by a local predictor, and every result is
// checked field by field against the oldest prediction. Both sides idle at
// random. The receiver also holds off for one long stretch, and the sender
// drains the pipe at two points.
// ----------------------------------------------------------------------------
module quad_corner_order_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qco_pkg::*;

  localparam int unsigned CW        = COORD_BITS_DEF;
  localparam int unsigned NUM_OUT   = 2 * NUM_PTS;
  localparam int unsigned MAX_WAIT  = 12;
  localparam int unsigned HOLD_LEN  = 80;
  localparam int unsigned HOLD_AT   = 120;
  localparam int unsigned N_RANDOM  = 450;
  localparam int unsigned TAIL_CYC  = 20;

  typedef logic [CW-1:0]   coord_t;
  typedef logic [2*CW:0]   dist_t;

  // one input transaction plus driver controls
  typedef struct {
    coord_t      x [NUM_PTS];
    coord_t      y [NUM_PTS];
    int unsigned gap;    // idle cycles before it is offered
    bit          drain;  // wait for an empty pipe before offering
  } quad_t;

  // ordered corners: tl.x tl.y tr.x tr.y br.x br.y bl.x bl.y
  typedef struct {
    coord_t c [NUM_OUT];
  } corners_t;

  string field_names [NUM_OUT] = '{"top_left_x", "top_left_y", "top_right_x",
                                   "top_right_y", "bottom_right_x",
                                   "bottom_right_y", "bottom_left_x",
                                   "bottom_left_y"};

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  coord_t in_x0_i, in_y0_i, in_x1_i, in_y1_i;
  coord_t in_x2_i, in_y2_i, in_x3_i, in_y3_i;
  logic   out_valid_o;
  logic   out_ready_i;
  coord_t top_left_x_o, top_left_y_o, top_right_x_o, top_right_y_o;
  coord_t bottom_right_x_o, bottom_right_y_o, bottom_left_x_o, bottom_left_y_o;

  quad_t       pending_q [$];
  corners_t    corner_q  [$];
  int unsigned err_cnt = 0;
  int unsigned in_cnt  = 0;
  int unsigned out_cnt = 0;
  int unsigned n_items = 0;
  bit          in_fire  = 1'b0;
  bit          out_fire = 1'b0;
  bit          stim_done = 1'b0;
  bit          rx_hold  = 1'b0;
  bit          gen_calm = 1'b0;
  bit          gen_drain = 1'b0;

  quad_corner_order_unit #(
    .COORD_BITS(CW)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_x0_i         (in_x0_i),
    .in_y0_i         (in_y0_i),
    .in_x1_i         (in_x1_i),
    .in_y1_i         (in_y1_i),
    .in_x2_i         (in_x2_i),
    .in_y2_i         (in_y2_i),
    .in_x3_i         (in_x3_i),
    .in_y3_i         (in_y3_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .top_left_x_o    (top_left_x_o),
    .top_left_y_o    (top_left_y_o),
    .top_right_x_o   (top_right_x_o),
    .top_right_y_o   (top_right_y_o),
    .bottom_right_x_o(bottom_right_x_o),
    .bottom_right_y_o(bottom_right_y_o),
    .bottom_left_x_o (bottom_left_x_o),
    .bottom_left_y_o (bottom_left_y_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic dist_t dist_sq(input coord_t ax, input coord_t ay,
                                    input coord_t bx, input coord_t by);
    coord_t dx;
    coord_t dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return dist_t'(dx) * dist_t'(dx) + dist_t'(dy) * dist_t'(dy);
  endfunction

  // predictor: rank by x (index breaks ties), split left pair by y,
  // right pair by squared distance to top-left
  function automatic corners_t order_corners(input quad_t q);
    coord_t   sx [NUM_PTS];
    coord_t   sy [NUM_PTS];
    idx_t     si [NUM_PTS];
    coord_t   tx;
    coord_t   ty;
    idx_t     ti;
    int       j;
    int       tl;
    int       bl;
    int       tr;
    int       br;
    dist_t    d2;
    dist_t    d3;
    corners_t r;
    for (int i = 0; i < NUM_PTS; i++) begin
      sx[i] = q.x[i];
      sy[i] = q.y[i];
      si[i] = idx_t'(i);
    end
    for (int i = 1; i < NUM_PTS; i++) begin
      tx = sx[i];
      ty = sy[i];
      ti = si[i];
      j  = i;
      while (j > 0 && (tx < sx[j-1] || (tx == sx[j-1] && ti < si[j-1]))) begin
        sx[j] = sx[j-1];
        sy[j] = sy[j-1];
        si[j] = si[j-1];
        j--;
      end
      sx[j] = tx;
      sy[j] = ty;
      si[j] = ti;
    end
    if (sy[1] < sy[0] || (sy[1] == sy[0] && si[1] < si[0])) begin
      tl = 1;
      bl = 0;
    end else begin
      tl = 0;
      bl = 1;
    end
    d2 = dist_sq(sx[tl], sy[tl], sx[2], sy[2]);
    d3 = dist_sq(sx[tl], sy[tl], sx[3], sy[3]);
    if (d3 < d2 || (d3 == d2 && si[3] < si[2])) begin
      tr = 3;
      br = 2;
    end else begin
      tr = 2;
      br = 3;
    end
    r.c[0] = sx[tl];
    r.c[1] = sy[tl];
    r.c[2] = sx[tr];
    r.c[3] = sy[tr];
    r.c[4] = sx[br];
    r.c[5] = sy[br];
    r.c[6] = sx[bl];
    r.c[7] = sy[bl];
    return r;
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic add_quad(input coord_t x0, input coord_t y0,
                          input coord_t x1, input coord_t y1,
                          input coord_t x2, input coord_t y2,
                          input coord_t x3, input coord_t y3);
    quad_t q;
    q.x   = '{x0, x1, x2, x3};
    q.y   = '{y0, y1, y2, y3};
    q.gap = gen_drain ? 0 : draw_wait(gen_calm);
    q.drain = gen_drain;
    gen_drain = 1'b0;
    pending_q = {pending_q, q};
    n_items++;
  endtask

  // stimulus: directed corner cases, then random shapes
  initial begin
    coord_t      px [NUM_PTS];
    coord_t      py [NUM_PTS];
    coord_t      tmp;
    int unsigned k;
    int unsigned cx;
    int unsigned cy;
    int unsigned hw;
    int unsigned hh;
    int unsigned lim;

    // extremes
    add_quad('0, '0, '0, '0, '0, '0, '0, '0);
    add_quad('1, '1, '1, '1, '1, '1, '1, '1);
    add_quad(12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hAAA, 12'hAAA, 12'h555, 12'h555);
    // full-frame square in every rotation of input order, plus one shuffled order
    add_quad(0, 0, 4095, 0, 4095, 4095, 0, 4095);
    add_quad(4095, 0, 4095, 4095, 0, 4095, 0, 0);
    add_quad(4095, 4095, 0, 4095, 0, 0, 4095, 0);
    add_quad(0, 4095, 0, 0, 4095, 0, 4095, 4095);
    add_quad(4095, 4095, 0, 0, 0, 4095, 4095, 0);
    // all x equal: ranking falls back to input index
    add_quad(100, 40, 100, 30, 100, 20, 100, 10);
    add_quad(7, 0, 7, 4095, 7, 0, 7, 4095);
    // equal y within the left pair
    add_quad(10, 50, 20, 50, 300, 10, 310, 90);
    add_quad(300, 10, 20, 50, 310, 90, 10, 50);
    // equal distance within the right pair
    add_quad(0, 0, 0, 10, 3, 4, 4, 3);
    add_quad(4, 3, 0, 10, 3, 4, 0, 0);
    add_quad(100, 100, 100, 200, 200, 0, 200, 200);
    // repeated points
    add_quad(50, 60, 50, 60, 50, 60, 50, 60);
    add_quad(4095, 4095, 4095, 4095, 0, 0, 0, 0);
    add_quad(9, 9, 9, 9, 20, 1, 20, 1);
    // collinear
    add_quad(0, 0, 1000, 1000, 2000, 2000, 3000, 3000);
    add_quad(3000, 0, 0, 3000, 2000, 1000, 1000, 2000);
    add_quad(0, 500, 4095, 500, 2000, 500, 1000, 500);
    // skewed quad with wide spans
    add_quad(4095, 1, 1, 4094, 4094, 4095, 0, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      // keep a burst of gap-free items around the long receiver hold-off
      gen_calm = (n >= 80 && n < 200) || ((n / 40) % 4 == 3);
      if (n == 250 || n == 380) gen_drain = 1'b1;
      k = $urandom_range(0, 9);
      if (k < 3) begin
        // uniform over the whole field
        for (int i = 0; i < NUM_PTS; i++) begin
          px[i] = coord_t'($urandom);
          py[i] = coord_t'($urandom);
        end
      end else if (k < 5) begin
        // tiny range: frequent ties in x, y and distance
        lim = (k == 3) ? 2 : 5;
        for (int i = 0; i < NUM_PTS; i++) begin
          px[i] = coord_t'($urandom_range(0, lim));
          py[i] = coord_t'($urandom_range(0, lim));
        end
      end else begin
        // jittered rectangle, corners shuffled
        hw = $urandom_range(1, 2000);
        hh = $urandom_range(1, 2000);
        cx = $urandom_range(hw + 40, 4095 - hw - 40);
        cy = $urandom_range(hh + 40, 4095 - hh - 40);
        px[0] = coord_t'(cx - hw + $urandom_range(0, 40) - 20);
        py[0] = coord_t'(cy - hh + $urandom_range(0, 40) - 20);
        px[1] = coord_t'(cx + hw + $urandom_range(0, 40) - 20);
        py[1] = coord_t'(cy - hh + $urandom_range(0, 40) - 20);
        px[2] = coord_t'(cx + hw + $urandom_range(0, 40) - 20);
        py[2] = coord_t'(cy + hh + $urandom_range(0, 40) - 20);
        px[3] = coord_t'(cx - hw + $urandom_range(0, 40) - 20);
        py[3] = coord_t'(cy + hh + $urandom_range(0, 40) - 20);
        for (int i = NUM_PTS - 1; i > 0; i--) begin
          lim = $urandom_range(0, i);
          tmp = px[i]; px[i] = px[lim]; px[lim] = tmp;
          tmp = py[i]; py[i] = py[lim]; py[lim] = tmp;
        end
      end
      add_quad(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
    end
    stim_done = 1'b1;
  end

  // input driver: holds a transaction until accepted, then idles or loads
  quad_t       staged;
  bit          have_staged = 1'b0;
  int unsigned tx_wait = 0;

  initial begin
    in_valid_i = 1'b0;
    {in_x0_i, in_y0_i, in_x1_i, in_y1_i} = '0;
    {in_x2_i, in_y2_i, in_x3_i, in_y3_i} = '0;
    out_ready_i = 1'b0;
  end

  task automatic present_quad(input quad_t q);
    in_valid_i <= 1'b1;
    in_x0_i    <= q.x[0];
    in_y0_i    <= q.y[0];
    in_x1_i    <= q.x[1];
    in_y1_i    <= q.y[1];
    in_x2_i    <= q.x[2];
    in_y2_i    <= q.y[2];
    in_x3_i    <= q.x[3];
    in_y3_i    <= q.y[3];
  endtask

  always @(negedge clk_i) begin
    quad_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_fire) begin
        // still waiting for acceptance
      end else if (tx_wait != 0) begin
        in_valid_i <= 1'b0;
        tx_wait--;
      end else if (have_staged) begin
        present_quad(staged);
        have_staged = 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && corner_q.size() != 0)) begin
        nxt = pending_q.pop_front();
        if (nxt.gap == 0) begin
          present_quad(nxt);
        end else begin
          in_valid_i <= 1'b0;
          staged      = nxt;
          have_staged = 1'b1;
          tx_wait     = nxt.gap - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: random stall per result, calm stretches, one long hold-off
  int unsigned rx_stall = 0;
  bit          rx_calm  = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        if (out_cnt % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        rx_stall = draw_wait(rx_calm);
      end else if (rx_stall != 0) begin
        rx_stall--;
      end
      out_ready_i <= (rx_stall == 0) && !rx_hold;
    end
  end

  initial begin
    @(posedge rst_ni);
    wait (in_cnt >= HOLD_AT);
    rx_hold = 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk_i) begin
    quad_t    q;
    corners_t got;
    corners_t want;
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        in_fire = 1'b1;
        in_cnt++;
        q.x = '{in_x0_i, in_x1_i, in_x2_i, in_x3_i};
        q.y = '{in_y0_i, in_y1_i, in_y2_i, in_y3_i};
        corner_q = {corner_q, order_corners(q)};
      end
      if (out_valid_o && out_ready_i) begin
        out_fire = 1'b1;
        out_cnt++;
        got.c = '{top_left_x_o, top_left_y_o, top_right_x_o, top_right_y_o,
                  bottom_right_x_o, bottom_right_y_o, bottom_left_x_o,
                  bottom_left_y_o};
        if (corner_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no transaction pending", out_cnt));
        end else begin
          want = corner_q.pop_front();
          for (int i = 0; i < NUM_OUT; i++) begin
            if (got.c[i] !== want.c[i])
              report_mismatch($sformatf("result %0d %s: got %0d want %0d",
                                        out_cnt, field_names[i], got.c[i], want.c[i]));
          end
        end
      end
    end
  end

  // end of run: every queued transaction accepted and every result checked
  initial begin
    @(posedge rst_ni);
    wait (stim_done);
    wait (in_cnt == n_items && corner_q.size() == 0);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (corner_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", corner_q.size()));
    if (err_cnt == 0) begin
      $display("quad_corner_order_unit: match");
    end else begin
      $display("quad_corner_order_unit: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("timeout: %0d results still expected", corner_q.size());
    $display("quad_corner_order_unit: mismatch");
    $finish;
  end

endmodule
